// ----- design/bomc_pkg.sv -----
// Package with shared types and constants for the bone offset matrix composer.
`default_nettype none
package bomc_pkg;
  localparam int NumJointsDef = 64;
  localparam logic [2:0] ActWrOffset = 3'd0;
  localparam logic [2:0] ActClear    = 3'd1;
  localparam logic [2:0] ActLdBone   = 3'd2;
  localparam logic [2:0] ActLdParent = 3'd3;
  localparam logic [2:0] ActApply    = 3'd4;
  localparam logic signed [31:0] QOne = 32'sd65536;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         joint;
    logic [3:0]         element;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic               applied;
    logic [3:0]         out_element;
    logic signed [31:0] out_value;
    logic               last;
  } out_beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ----- design/bomc_mac.sv -----
// Multiply-accumulate unit: registered Q16.16 product, wide accumulator.
`default_nettype none
module bomc_mac (
  input  wire logic               clk,
  input  wire logic               clr,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [49:0]      acc
);
  import bomc_pkg::*;
  logic signed [63:0] prod_r;
  logic               vld_r;
  logic               clr_r;
  logic signed [49:0] acc_r;
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    vld_r  <= en;
    clr_r  <= clr;
    if (vld_r) begin
      acc_r <= (clr_r ? 50'sd0 : acc_r) + 50'(prod_r >>> 16);
    end
  end
  assign acc = acc_r;
endmodule
`default_nettype wire

// ----- design/bone_offset_matrix_compose_top.sv -----
// Top level of the bone offset matrix composer.
// Loads and clears are taken in the idle state, which they do not leave. An apply for an
// invalid joint passes through StInv, which loads its beat into the output register. A
// valid apply runs 28 dot products of four terms through one multiplier, plus a translation
// pass for row 3; the input is stalled until the last beat loads.
// Reset (synchronous, active low) clears the valid flags and control; stores keep data.
`default_nettype none
module bone_offset_matrix_compose_top #(
  parameter int NUM_JOINTS = bomc_pkg::NumJointsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bomc_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bomc_pkg::out_beat_t     out_data
);
  import bomc_pkg::*;
  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int AW = JW + 4;
  localparam logic [2:0] StIdle = 3'd0, StMid = 3'd1, StOut = 3'd2, StWait = 3'd3,
                         StInv = 3'd4;

  // Offset table in one synchronous memory; bone, parent and intermediate are small.
  logic signed [31:0] off_mem [NUM_JOINTS*16];
  logic signed [31:0] bone_r [16];
  logic signed [31:0] par_r [16];
  logic signed [31:0] mid_r [16];
  logic [NUM_JOINTS-1:0] valid_r;
  logic signed [31:0] off_q;

  logic [2:0] st_r;
  logic [JW-1:0] jnt_r;
  logic [3:0] idx_r;   // result element being formed
  logic [2:0] k_r;     // term step within a dot product, 0..6
  logic ob_v_r;
  out_beat_t ob_r;

  wire acc_in = in_valid && !in_stall;
  wire in_rng = (32'(in_data.joint) < NUM_JOINTS);
  wire [JW-1:0] jin = in_data.joint[JW-1:0];
  // The output register takes a new beat when it is free or being emptied this cycle.
  wire ob_load = ((st_r == StInv) || (st_r == StOut && k_r == 3'd6)) &&
                 (!ob_v_r || !out_stall);
  assign in_stall = (st_r != StIdle) || (ob_v_r && out_stall);
  assign out_valid = ob_v_r;
  assign out_data = ob_r;

  // Offset read address: row of idx, term k; the translation pass reads its column.
  wire [1:0] kk = (st_r == StMid && idx_r[3:2] == 2'd3) ? idx_r[1:0] : k_r[1:0];
  wire [AW-1:0] rd_a = {jnt_r, idx_r[3:2], kk};
  always_ff @(posedge clk) begin
    if (acc_in && in_data.action == ActWrOffset && in_rng)
      off_mem[{jin, in_data.element}] <= in_data.value;
    off_q <= off_mem[rd_a];
  end

  // Operand select; the offset term is registered and arrives in the cycle after its address.
  logic [1:0] kp_r;
  logic       en_r, clr_r;
  always_ff @(posedge clk) begin
    kp_r  <= kk;
    en_r  <= (st_r == StMid || st_r == StOut) && k_r < 3'd4;
    clr_r <= (k_r == 3'd0);
  end
  wire signed [31:0] ma = (st_r == StMid) ? off_q : mid_r[{idx_r[3:2], kp_r}];
  wire signed [31:0] mb = (st_r == StMid) ? bone_r[{kp_r, idx_r[1:0]}]
                                          : par_r[{kp_r, idx_r[1:0]}];
  logic signed [49:0] acc;
  bomc_mac u_mac (.clk, .clr(clr_r), .en(en_r), .a(ma), .b(mb), .acc);

  // Row 3 translation term, read from the offset store in its own short pass.
  wire signed [31:0] tsum = sat32(50'(bone_r[{2'd3, idx_r[1:0]}]) + 50'(off_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; valid_r <= '0; ob_v_r <= 1'b0; k_r <= '0; idx_r <= '0;
    end else begin
      if (ob_load) ob_v_r <= 1'b1;
      else if (ob_v_r && !out_stall) ob_v_r <= 1'b0;
      unique case (st_r)
        StIdle: begin
          if (acc_in) begin
            unique case (in_data.action)
              ActWrOffset: if (in_rng) valid_r[jin] <= 1'b1;
              ActClear:    valid_r <= '0;
              ActLdBone:   bone_r[in_data.element] <= in_data.value;
              ActLdParent: par_r[in_data.element] <= in_data.value;
              ActApply: begin
                jnt_r <= jin; idx_r <= '0; k_r <= '0;
                st_r <= (in_rng && valid_r[jin]) ? StMid : StInv;
              end
              default: ;
            endcase
          end
        end
        StInv: begin
          if (ob_load) begin
            ob_r <= '{applied: 1'b0, out_element: 4'd0, out_value: '0, last: 1'b1};
            st_r <= StIdle;
          end
        end
        StMid: begin
          // Rows 0-2 need the MAC; row 3 reads the offset element of its column.
          if (idx_r[3:2] == 2'd3) begin
            if (k_r == 3'd0) begin
              if (idx_r[1:0] == 2'd3) begin
                mid_r[15] <= QOne; idx_r <= '0; st_r <= StOut;
              end else k_r <= 3'd4;
            end else if (k_r == 3'd4) begin
              k_r <= 3'd5;
            end else begin
              mid_r[idx_r] <= tsum; k_r <= '0; idx_r <= idx_r + 4'd1;
            end
          end else if (k_r == 3'd6) begin
            mid_r[idx_r] <= sat32(acc); k_r <= '0; idx_r <= idx_r + 4'd1;
          end else k_r <= k_r + 3'd1;
        end
        StOut: begin
          if (k_r == 3'd6) begin
            if (ob_load) begin
              ob_r <= '{applied: 1'b1, out_element: idx_r, out_value: sat32(acc),
                        last: (idx_r == 4'd15)};
              k_r <= '0; idx_r <= idx_r + 4'd1;
              if (idx_r == 4'd15) st_r <= StIdle;
            end
          end else k_r <= k_r + 3'd1;
        end
        default: st_r <= StIdle;
      endcase
    end
  end
  // Row 3 addressing: during the translation pass kk holds the column, so off_q
  // arrives while k_r is 4, and tsum is taken when k_r is 5.
endmodule
`default_nettype wire

// ----- design/bomc_checker.sv -----
// Port-level checker for the composer, bound to the top level.
`default_nettype none
module bomc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire bomc_pkg::in_beat_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bomc_pkg::out_beat_t out_data
);
  import bomc_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.applied |-> out_data.last) else $error("invalid not last");
  a_lastel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.applied |-> (out_data.last == (out_data.out_element == 4'd15)))
    else $error("last mismatch");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action != ActApply && !out_valid |=> !out_valid)
    else $error("load gave result");
endmodule
bind bone_offset_matrix_compose_top bomc_checker u_chk (.*);
`default_nettype wire

// ----- tb/bone_offset_matrix_compose_top_test.sv -----
// Self-checking testbench for the bone offset matrix composer top level.
`timescale 1ns / 1ps
`default_nettype none
module bone_offset_matrix_compose_top_test;
  import bomc_pkg::*;

  // Action codes that the block has no use for; they must pass without a result.
  localparam logic [2:0] ActSpare5 = 3'd5;
  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;
  localparam int NumJoints = NumJointsDef;
  localparam int RandomItems = 220;
  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;
  localparam out_beat_t NoApply = '{applied: 1'b0, out_element: 4'd0, out_value: 32'sd0,
                                    last: 1'b1};

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  bone_offset_matrix_compose_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // The testbench's own picture of the block's stores.
  logic signed [31:0] offsets [NumJoints][16];
  bit                 joint_live [NumJoints];
  logic signed [31:0] bone [16];
  logic signed [31:0] parent [16];
  // Which entries have been written, so that no apply reads an unwritten one.
  logic [15:0]        offset_seen [NumJoints];
  logic [15:0]        bone_seen;
  logic [15:0]        parent_seen;

  out_beat_t pending_beats [$];
  int        mismatches;
  int        beats_sent;
  int        beats_checked;
  int        applies_done;
  int        out_cycle;

  dir_row_t directed_rows [13] = '{
    // Straight after reset no joint has an offset, so both ends answer with no apply.
    '{'{action: ActApply, joint: 6'd0, element: 4'd0, value: 32'sd0}, 1'b1, NoApply},
    '{'{action: ActApply, joint: 6'd63, element: 4'd15, value: QMax}, 1'b1, NoApply},
    // Spare action codes are ignored whatever they carry.
    '{'{action: ActSpare5, joint: 6'd63, element: 4'd15, value: QMax}, 1'b0, NoApply},
    '{'{action: ActSpare6, joint: 6'd0, element: 4'd0, value: QMin}, 1'b0, NoApply},
    '{'{action: ActSpare7, joint: 6'd42, element: 4'd5, value: -32'sd1}, 1'b0, NoApply},
    '{'{action: ActClear, joint: 6'd21, element: 4'd10, value: 32'sd1}, 1'b0, NoApply},
    '{'{action: ActLdBone, joint: 6'd0, element: 4'd0, value: QMin}, 1'b0, NoApply},
    '{'{action: ActLdParent, joint: 6'd63, element: 4'd15, value: QMax}, 1'b0, NoApply},
    '{'{action: ActWrOffset, joint: 6'd63, element: 4'd15, value: QMax}, 1'b0, NoApply},
    '{'{action: ActWrOffset, joint: 6'd0, element: 4'd0, value: QMin}, 1'b0, NoApply},
    // A clear drops the valid flags, so the joints written above answer as empty.
    '{'{action: ActClear, joint: 6'd0, element: 4'd0, value: 32'sd0}, 1'b0, NoApply},
    '{'{action: ActApply, joint: 6'd63, element: 4'd3, value: 32'sd7}, 1'b1, NoApply},
    '{'{action: ActApply, joint: 6'd0, element: 4'd12, value: QMin}, 1'b1, NoApply}
  };

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Saturate a wide sum to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_q(input longint v);
    if (v > 64'sd2147483647) return QMax;
    if (v < -64'sd2147483648) return QMin;
    return v[31:0];
  endfunction

  // Q16.16 product; the arithmetic shift drops the low bits towards minus infinity.
  function automatic longint q_product(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  // Works out what one accepted input beat does to the stores and what it answers.
  task automatic track_beat(input in_beat_t b, output out_beat_t answers [$]);
    logic signed [31:0] mid [16];
    longint acc;
    out_beat_t o;
    answers = {};
    case (b.action)
      ActWrOffset: begin
        offsets[b.joint][b.element] = b.value;
        offset_seen[b.joint][b.element] = 1'b1;
        joint_live[b.joint] = 1'b1;
      end
      ActClear: begin
        foreach (joint_live[j]) joint_live[j] = 1'b0;
      end
      ActLdBone: begin
        bone[b.element] = b.value;
        bone_seen[b.element] = 1'b1;
      end
      ActLdParent: begin
        parent[b.element] = b.value;
        parent_seen[b.element] = 1'b1;
      end
      ActApply: begin
        if (!joint_live[b.joint]) begin
          answers.push_back(NoApply);
        end else begin
          // Rows 0 to 2 are offset times bone; row 3 is the summed translation.
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
              acc = 0;
              for (int k = 0; k < 4; k++) acc += q_product(offsets[b.joint][r*4+k], bone[k*4+c]);
              mid[r*4+c] = clamp_q(acc);
            end
          end
          for (int c = 0; c < 3; c++)
            mid[12+c] = clamp_q(longint'(bone[12+c]) + longint'(offsets[b.joint][12+c]));
          mid[15] = QOne;
          for (int idx = 0; idx < 16; idx++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += q_product(mid[(idx/4)*4+k], parent[k*4+idx%4]);
            o.applied = 1'b1;
            o.out_element = idx[3:0];
            o.out_value = clamp_q(acc);
            o.last = (idx == 15);
            answers.push_back(o);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Idle with a chance of about one in ten, except in a quiet stretch in the middle of the run.
  function automatic bit idle_now(input int progress, input int quiet_lo, input int quiet_hi);
    if (progress >= quiet_lo && progress < quiet_hi) return 1'b0;
    return $urandom_range(0, 99) < 10;
  endfunction

  // Offers one beat from the falling edge on and holds it until the block takes it.
  // The prediction is made at the accepting edge; typed rows replace it with their answer.
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t answers [$];
    while (idle_now(beats_sent, 80, 140)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    track_beat(b, answers);
    if (typed) pending_beats.push_back(want);
    else foreach (answers[i]) pending_beats.push_back(answers[i]);
    if (b.action == ActApply && joint_live[b.joint]) applies_done++;
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Small Q16.16 values between -4 and 4, with the extremes, zero and raw words mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return QMax;
      1: return QMin;
      2: return 32'sd0;
      3, 4, 5, 6: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_plain(input logic [2:0] act, input logic [5:0] j, input logic [3:0] e,
                            input logic signed [31:0] v);
    in_beat_t b;
    b.action = act;
    b.joint = j;
    b.element = e;
    b.value = v;
    send_beat(b, 1'b0, NoApply);
  endtask

  // An apply is only sent where every entry it would read has been written.
  function automatic bit apply_safe(input logic [5:0] j);
    if (!joint_live[j]) return 1'b1;
    return offset_seen[j] == 16'hffff && bone_seen == 16'hffff && parent_seen == 16'hffff;
  endfunction

  initial begin
    in_beat_t b;
    logic [5:0] j;
    int kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    applies_done = 0;
    bone_seen = '0;
    parent_seen = '0;
    foreach (joint_live[i]) begin
      joint_live[i] = 1'b0;
      offset_seen[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    // Random part: mostly complete set-ups followed by an apply, with noise between.
    while (beats_sent < RandomItems) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if (bone_seen != 16'hffff || parent_seen != 16'hffff) begin
          for (int e = 0; e < 16; e++) send_plain(ActLdBone, 6'd0, e[3:0], pick_value());
          for (int e = 0; e < 16; e++) send_plain(ActLdParent, 6'd0, e[3:0], pick_value());
        end else begin
          repeat ($urandom_range(0, 3))
            send_plain(ActLdBone, 6'($urandom), 4'($urandom), pick_value());
          repeat ($urandom_range(0, 3))
            send_plain(ActLdParent, 6'($urandom), 4'($urandom), pick_value());
        end
        j = 6'($urandom);
        if (offset_seen[j] != 16'hffff) begin
          for (int e = 0; e < 16; e++) send_plain(ActWrOffset, j, e[3:0], pick_value());
        end else begin
          repeat ($urandom_range(1, 3)) send_plain(ActWrOffset, j, 4'($urandom), pick_value());
        end
        send_plain(ActApply, j, 4'($urandom), $urandom);
      end else if (kind == 7) begin
        send_plain(ActClear, 6'($urandom), 4'($urandom), $urandom);
        send_plain(ActApply, 6'($urandom), 4'($urandom), $urandom);
      end else begin
        repeat (6) begin
          b = in_beat_t'(45'({$urandom, $urandom}));
          if (b.action == ActApply && !apply_safe(b.joint)) b.action = ActWrOffset;
          send_beat(b, 1'b0, NoApply);
        end
      end
    end

    while (pending_beats.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d input beats, %0d of them applies on live joints; checked %0d results.",
             beats_sent, applies_done, beats_checked);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("bone_offset_matrix_compose_top_test passed");
    end else begin
      $display("bone_offset_matrix_compose_top_test failed");
    end
    $finish;
  end

  // The result side stalls at random too, with its own quiet stretch.
  initial begin
    out_stall = 1'b0;
    out_cycle = 0;
    forever begin
      @(negedge clk);
      out_cycle++;
      out_stall = idle_now(out_cycle, 3000, 6000);
    end
  end

  // Each accepted result beat is checked against the oldest one still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: result beat with none expected, actual %p", $realtime, out_data);
        mismatches++;
      end else begin
        if (out_data.applied !== pending_beats[0].applied
            || out_data.out_element !== pending_beats[0].out_element
            || out_data.out_value !== pending_beats[0].out_value
            || out_data.last !== pending_beats[0].last) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, pending_beats[0],
                   out_data);
          mismatches++;
        end
        void'(pending_beats.pop_front());
        beats_checked++;
      end
    end
  end

  // The time limit leaves ample room over the slowest run.
  initial begin
    #4000000;
    $display("bone_offset_matrix_compose_top_test failed");
    $finish;
  end
endmodule
`default_nettype wire
